/* src/lfuc_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache package
// Shared widths, constants and types of the LFU cache table.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int CFG_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int STAMP_W = 48;

  localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    CMD_TOUCH,
    CMD_UPDATE,
    CMD_INSERT
  } cmd_kind_t;

  typedef struct packed {
    logic               valid;
    logic               have_found;
    logic               have_free;
    logic               have_victim;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] victim_count;
    logic [STAMP_W-1:0] victim_stamp;
  } wave_t;

  typedef struct packed {
    logic               valid;
    cmd_kind_t          kind;
    logic [STAMP_W-1:0] stamp;
  } commit_t;

endpackage

/* src/lfuc_cell.sv */
// ----------------------------------------------------------------------------
// LFU cache cell
// Holds one entry, folds it into the passing search token and applies the
// broadcast update when the update names this slot.
// ----------------------------------------------------------------------------
module lfuc_cell import lfuc_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int INDEX    = 0,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int UW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  wave_t              wave_in,
  input  logic [IW-1:0]      found_in,
  input  logic [IW-1:0]      free_in,
  input  logic [IW-1:0]      victim_in,
  input  logic [UW-1:0]      used_in,
  output wave_t              wave_out,
  output logic [IW-1:0]      found_out,
  output logic [IW-1:0]      free_out,
  output logic [IW-1:0]      victim_out,
  output logic [UW-1:0]      used_out,
  input  logic [KEY_W-1:0]   req_key,
  input  logic [VALUE_W-1:0] req_value,
  input  commit_t            commit,
  input  logic [IW-1:0]      commit_slot
);

  localparam logic [IW-1:0] MY_SLOT = IW'(INDEX);

  logic               entry_valid;
  logic [KEY_W-1:0]   entry_key;
  logic [VALUE_W-1:0] entry_value;
  logic [COUNT_W-1:0] entry_count;
  logic [STAMP_W-1:0] entry_stamp;

  wave_t         wave_next;
  logic [IW-1:0] found_next;
  logic [IW-1:0] free_next;
  logic [IW-1:0] victim_next;
  logic [UW-1:0] used_next;
  logic          selected;

  assign selected = commit.valid && (commit_slot == MY_SLOT);

  always_comb begin
    wave_next   = wave_in;
    found_next  = found_in;
    free_next   = free_in;
    victim_next = victim_in;
    used_next   = used_in;
    if (entry_valid) begin
      used_next = used_in + UW'(1);
      if (!wave_in.have_found && (entry_key == req_key)) begin
        wave_next.have_found = 1'b1;
        wave_next.read_value = entry_value;
        found_next           = MY_SLOT;
      end
      if (!wave_in.have_victim ||
          ({entry_count, entry_stamp} < {wave_in.victim_count, wave_in.victim_stamp})) begin
        wave_next.have_victim  = 1'b1;
        wave_next.victim_count = entry_count;
        wave_next.victim_stamp = entry_stamp;
        victim_next            = MY_SLOT;
      end
    end else if (!wave_in.have_free) begin
      wave_next.have_free = 1'b1;
      free_next           = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= wave_next;
    end
  end

  always_ff @(posedge clk) begin
    found_out  <= found_next;
    free_out   <= free_next;
    victim_out <= victim_next;
    used_out   <= used_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (selected && (commit.kind == CMD_INSERT)) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (selected) begin
      entry_stamp <= commit.stamp;
      case (commit.kind)
        CMD_TOUCH: begin
          if (entry_count != COUNT_MAX) begin
            entry_count <= entry_count + COUNT_W'(1);
          end
        end
        CMD_UPDATE: begin
          if (entry_count != COUNT_MAX) begin
            entry_count <= entry_count + COUNT_W'(1);
          end
          entry_value <= req_value;
        end
        CMD_INSERT: begin
          entry_key   <= req_key;
          entry_value <= req_value;
          entry_count <= COUNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/lfuc_ctrl.sv */
// ----------------------------------------------------------------------------
// LFU cache controller
// Takes requests, launches the search token, decides hit, insert or
// eviction from the token that leaves the chain and issues any update.
// ----------------------------------------------------------------------------
module lfuc_ctrl import lfuc_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int UW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [63:0]        s_tdata,
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  output logic [1:0]         m_tuser,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               launch,
  input  wave_t              last_wave,
  input  logic [IW-1:0]      last_found,
  input  logic [IW-1:0]      last_free,
  input  logic [IW-1:0]      last_victim,
  input  logic [UW-1:0]      last_used,
  output logic [KEY_W-1:0]   req_key,
  output logic [VALUE_W-1:0] req_value,
  output commit_t            commit,
  output logic [IW-1:0]      commit_slot
);

  localparam int LW = ((UW > CFG_W) ? UW : CFG_W) + 1;
  localparam logic [LW-1:0] LIMIT_MAX = LW'(CAPACITY);

  state_t state;
  state_t state_next;

  logic               req_op;
  logic [CFG_W-1:0]   cap;
  logic [STAMP_W-1:0] touch_counter;

  wave_t         held;
  logic [IW-1:0] held_found;
  logic [IW-1:0] held_free;
  logic [IW-1:0] held_victim;
  logic [UW-1:0] held_used;

  logic        out_valid;
  logic        out_hit;
  logic        out_evicted;
  logic [31:0] out_value;

  logic          accept;
  logic          decide_fire;
  logic [LW-1:0] limit;
  logic          full;
  logic          evict;
  logic          needs_commit;
  cmd_kind_t     kind;
  logic [IW-1:0] slot;

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_value;
  assign m_tuser   = {out_evicted, out_hit};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SEARCH;
      ST_SEARCH: if (last_wave.valid) state_next = ST_DECIDE;
      ST_DECIDE: if (!out_valid || m_tready) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == ST_IDLE);
    decide_fire = (state == ST_DECIDE) && (!out_valid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_comb begin
    limit = LW'(cap);
    if (limit == '0) begin
      limit = LW'(1);
    end
    if (limit > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end
    full         = (LW'(held_used) >= limit) || !held.have_free;
    evict        = !held.have_found && (req_op == OP_PUT) && full && held.have_victim;
    needs_commit = held.have_found || (req_op == OP_PUT);
    if (held.have_found) begin
      kind = (req_op == OP_PUT) ? CMD_UPDATE : CMD_TOUCH;
      slot = held_found;
    end else begin
      kind = CMD_INSERT;
      slot = evict ? held_victim : held_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      launch        <= 1'b0;
      cap           <= CAP_RESET;
      touch_counter <= '0;
      out_valid     <= 1'b0;
      commit.valid  <= 1'b0;
    end else begin
      state        <= state_next;
      launch       <= accept;
      commit.valid <= decide_fire && needs_commit;
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (decide_fire && needs_commit) begin
        touch_counter <= touch_counter + STAMP_W'(1);
      end
      if (decide_fire) begin
        commit.kind  <= kind;
        commit.stamp <= touch_counter;
      end
      if (decide_fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= s_tuser;
      req_key   <= s_tdata[31:0];
      req_value <= s_tdata[63:32];
    end
    if ((state == ST_SEARCH) && last_wave.valid) begin
      held        <= last_wave;
      held_found  <= last_found;
      held_free   <= last_free;
      held_victim <= last_victim;
      held_used   <= last_used;
    end
    if (decide_fire) begin
      out_hit      <= held.have_found;
      out_evicted  <= evict;
      out_value    <= (held.have_found && (req_op == OP_GET)) ? held.read_value : '0;
      commit_slot  <= slot;
    end
  end

endmodule

/* src/lfu_cache_table.sv */
// ----------------------------------------------------------------------------
// LFU cache table
// Key-value cache with least-frequently-used replacement and a
// least-recently-touched tie break, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// A result is offered once the controller decides. A new item is accepted
// only when the controller is idle again after the previous one; the search
// token walks the cell chain one cell per cycle, then the controller decides
// (waiting while an earlier result is held) and writes the chosen cell. A held
// result does not block the next search. Synchronous reset empties the table,
// clears the touch counter and sets the capacity register to 16.
module lfu_cache_table import lfuc_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // key [31:0], write_value [63:32]
  input  logic             s_tuser,   // opcode
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // read_value [31:0]
  output logic [1:0]       m_tuser,   // hit [0], evicted [1]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data   // capacity_in_use
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW = $clog2(CAPACITY + 1);

  wave_t         wave       [CAPACITY+1];
  logic [IW-1:0] found_idx  [CAPACITY+1];
  logic [IW-1:0] free_idx   [CAPACITY+1];
  logic [IW-1:0] victim_idx [CAPACITY+1];
  logic [UW-1:0] used       [CAPACITY+1];

  logic               launch;
  logic [KEY_W-1:0]   req_key;
  logic [VALUE_W-1:0] req_value;
  commit_t            commit;
  logic [IW-1:0]      commit_slot;

  // The valid flag is the top bit of the token.
  assign wave[0]       = {launch, {($bits(wave_t) - 1){1'b0}}};
  assign found_idx[0]  = '0;
  assign free_idx[0]   = '0;
  assign victim_idx[0] = '0;
  assign used[0]       = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lfuc_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .wave_in     (wave[i]),
      .found_in    (found_idx[i]),
      .free_in     (free_idx[i]),
      .victim_in   (victim_idx[i]),
      .used_in     (used[i]),
      .wave_out    (wave[i+1]),
      .found_out   (found_idx[i+1]),
      .free_out    (free_idx[i+1]),
      .victim_out  (victim_idx[i+1]),
      .used_out    (used[i+1]),
      .req_key     (req_key),
      .req_value   (req_value),
      .commit      (commit),
      .commit_slot (commit_slot)
    );
  end

  lfuc_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .launch      (launch),
    .last_wave   (wave[CAPACITY]),
    .last_found  (found_idx[CAPACITY]),
    .last_free   (free_idx[CAPACITY]),
    .last_victim (victim_idx[CAPACITY]),
    .last_used   (used[CAPACITY]),
    .req_key     (req_key),
    .req_value   (req_value),
    .commit      (commit),
    .commit_slot (commit_slot)
  );

endmodule

/* src/lfuc_checker.sv */
// ----------------------------------------------------------------------------
// LFU cache checker
// Port-level properties of the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
module lfuc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_evict_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("eviction reported together with a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
    else $error("read value not zero on a miss");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

endmodule

bind lfu_cache_table lfuc_checker u_checker (.*);
